[sv/fcf_pkg.sv]
// Package with shared constants, request codes and control types of the FIR filter.
`timescale 1ns / 1ps

package fcf_pkg;

  localparam int unsigned MaxTapsDefault    = 64;
  localparam int unsigned SampleBitsDefault = 24;
  localparam int unsigned AccBits           = 56;
  localparam int unsigned NumTapsWidth      = 7;
  localparam int unsigned TapIndexWidth     = 6;
  localparam int unsigned ReqWidth          = 2;

  localparam logic [ReqWidth-1:0] REQ_SAMPLE    = 2'd0;
  localparam logic [ReqWidth-1:0] REQ_COEF      = 2'd1;
  localparam logic [ReqWidth-1:0] REQ_CLEAR     = 2'd2;

  typedef struct packed {
    logic hist_clr;
    logic hist_shift;
    logic ring_rot;
  } cell_ctrl_t;

endpackage

[sv/fir_convolution_filter_core.sv]
// Top level of the streaming FIR filter: cell row, control sequencer and result register.
`timescale 1ns / 1ps

// An accepted sample word takes the sequencer through its run, drain and
// finish states; its result is loaded into the output register as the
// sequencer returns to idle, and only then is the next word accepted. The
// single multiply-accumulate unit at the head of the cell row limits the
// sample rate, as the row rotates once past it. If the previous result is
// still stalled when a sum is finished, the block waits until the output
// register is free. Coefficient and clear words keep the sequencer idle. A
// new word is accepted while a finished result waits in the output register.

module fir_convolution_filter_core #(
  parameter int unsigned MAX_TAPS    = fcf_pkg::MaxTapsDefault,
  parameter int unsigned SAMPLE_BITS = fcf_pkg::SampleBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [fcf_pkg::ReqWidth-1:0]         req_type_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in_i,
  input  logic [fcf_pkg::TapIndexWidth-1:0]    tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0]        tap_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        sample_out_o,
  output logic                                 clipped_o,
  input  logic                                 cfg_we_i,
  input  logic [fcf_pkg::NumTapsWidth-1:0]     cfg_wdata_i
);

  localparam int unsigned CntW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CmpW = (fcf_pkg::NumTapsWidth > CntW + 1) ?
                                 fcf_pkg::NumTapsWidth : CntW + 1;
  localparam int unsigned IdxW = (fcf_pkg::TapIndexWidth > CntW + 1) ?
                                 fcf_pkg::TapIndexWidth : CntW + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]                       state_q, state_d;
  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic [fcf_pkg::NumTapsWidth-1:0] num_taps_q;
  logic                             out_valid_q;
  logic [SAMPLE_BITS-1:0]           sample_out_q;
  logic                             clipped_q;

  logic                             accept;
  logic                             idx_ok;
  logic                             coef_wr;
  logic                             tap_used;
  logic                             out_free;
  fcf_pkg::cell_ctrl_t              ctrl;
  logic [MAX_TAPS-1:0]              coef_we;
  logic signed [SAMPLE_BITS-1:0]    coef_w [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0]    hist_w [MAX_TAPS];
  logic [SAMPLE_BITS-1:0]           mac_sample;
  logic                             mac_clip;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_ok     = IdxW'(tap_index_i) < IdxW'(MAX_TAPS);
  assign coef_wr    = accept && (req_type_i == fcf_pkg::REQ_COEF) && idx_ok;
  assign tap_used   = CmpW'(cnt_q) < CmpW'(num_taps_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    ctrl.hist_clr   = coef_wr || (accept && (req_type_i == fcf_pkg::REQ_CLEAR));
    ctrl.hist_shift = accept && (req_type_i == fcf_pkg::REQ_SAMPLE);
    ctrl.ring_rot   = (state_q == ST_RUN);
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    assign coef_we[k] = coef_wr && (IdxW'(tap_index_i) == IdxW'(k));

    if (k == 0) begin : g_head
      fcf_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .coef_we_i    (coef_we[k]),
        .coef_wdata_i (tap_value_i),
        .hist_prev_i  (sample_in_i),
        .coef_next_i  (coef_w[(k + 1) % MAX_TAPS]),
        .hist_next_i  (hist_w[(k + 1) % MAX_TAPS]),
        .coef_o       (coef_w[k]),
        .hist_o       (hist_w[k])
      );
    end else begin : g_body
      fcf_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .ctrl_i       (ctrl),
        .coef_we_i    (coef_we[k]),
        .coef_wdata_i (tap_value_i),
        .hist_prev_i  (hist_w[k - 1]),
        .coef_next_i  (coef_w[(k + 1) % MAX_TAPS]),
        .hist_next_i  (hist_w[(k + 1) % MAX_TAPS]),
        .coef_o       (coef_w[k]),
        .hist_o       (hist_w[k])
      );
    end
  end

  fcf_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ctrl.hist_shift),
    .mul_en_i ((state_q == ST_RUN) && tap_used),
    .coef_i   (coef_w[0]),
    .hist_i   (hist_w[0]),
    .sample_o (mac_sample),
    .clip_o   (mac_clip)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (ctrl.hist_shift) begin
          state_d = ST_RUN;
          cnt_d   = '0;
        end
      end
      ST_RUN: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(MAX_TAPS - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      num_taps_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        num_taps_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_FIN) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FIN) && out_free) begin
      sample_out_q <= mac_sample;
      clipped_q    <= mac_clip;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

  a_sample_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i == fcf_pkg::REQ_SAMPLE)) |=> (state_q == ST_RUN))
    else $error("Accepted sample word did not start the tap sweep.");

  a_other_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i != fcf_pkg::REQ_SAMPLE)) |=> (state_q == ST_IDLE))
    else $error("A non-sample word left the sequencer busy.");

  a_full_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> ($past(cnt_q) == CntW'(MAX_TAPS - 1)))
    else $error("Tap sweep ended before the ring turned fully.");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("Result word appeared without a finished sum.");

endmodule

[sv/fcf_cell.sv]
// One filter cell holding a coefficient and a delayed sample, linked to its neighbours.
`timescale 1ns / 1ps

module fcf_cell #(
  parameter int unsigned SAMPLE_BITS = fcf_pkg::SampleBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fcf_pkg::cell_ctrl_t           ctrl_i,
  input  logic                          coef_we_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_wdata_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_prev_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_next_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_next_i,
  output logic signed [SAMPLE_BITS-1:0] coef_o,
  output logic signed [SAMPLE_BITS-1:0] hist_o
);

  logic signed [SAMPLE_BITS-1:0] coef_q;
  logic signed [SAMPLE_BITS-1:0] hist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (coef_we_i) begin
      coef_q <= coef_wdata_i;
    end else if (ctrl_i.ring_rot) begin
      coef_q <= coef_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (ctrl_i.hist_clr) begin
      hist_q <= '0;
    end else if (ctrl_i.hist_shift) begin
      hist_q <= hist_prev_i;
    end else if (ctrl_i.ring_rot) begin
      hist_q <= hist_next_i;
    end
  end

  assign coef_o = coef_q;
  assign hist_o = hist_q;

endmodule

[sv/fcf_mac.sv]
// Multiply-accumulate unit with rounding and saturation of the final sum.
`timescale 1ns / 1ps

module fcf_mac #(
  parameter int unsigned SAMPLE_BITS = fcf_pkg::SampleBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          mul_en_i,
  input  logic signed [SAMPLE_BITS-1:0] coef_i,
  input  logic signed [SAMPLE_BITS-1:0] hist_i,
  output logic        [SAMPLE_BITS-1:0] sample_o,
  output logic                          clip_o
);

  localparam int unsigned AccW  = fcf_pkg::AccBits;
  localparam int unsigned ProdW = 2 * SAMPLE_BITS;
  localparam int unsigned Frac  = SAMPLE_BITS - 1;
  localparam logic signed [AccW:0] MaxV = (AccW+1)'((64'sd1 <<< Frac) - 64'sd1);
  localparam logic signed [AccW:0] MinV = (AccW+1)'(-(64'sd1 <<< Frac));
  localparam logic signed [AccW:0] Half = (AccW+1)'(64'sd1 <<< (Frac - 1));

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_en_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW:0]    rnd;
  logic signed [AccW:0]    quo;

  always_ff @(posedge clk_i) begin
    prod_q <= coef_i * hist_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_en_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      prod_en_q <= mul_en_i;
      if (start_i) begin
        acc_q <= '0;
      end else if (prod_en_q) begin
        acc_q <= acc_q + AccW'(prod_q);
      end
    end
  end

  always_comb begin
    rnd = (AccW+1)'(acc_q) + Half;
    quo = rnd >>> Frac;
    if (quo > MaxV) begin
      sample_o = MaxV[SAMPLE_BITS-1:0];
      clip_o   = 1'b1;
    end else if (quo < MinV) begin
      sample_o = MinV[SAMPLE_BITS-1:0];
      clip_o   = 1'b1;
    end else begin
      sample_o = quo[SAMPLE_BITS-1:0];
      clip_o   = 1'b0;
    end
  end

endmodule

[test/fir_convolution_filter_core_tb.sv]
// Self-checking testbench of the streaming FIR filter core with a scoreboard class.
`timescale 1ns / 1ps

module fir_convolution_filter_core_tb;

  localparam int unsigned NumTaps    = fcf_pkg::MaxTapsDefault;
  localparam int unsigned SampleW    = fcf_pkg::SampleBitsDefault;
  localparam int unsigned FracBits   = SampleW - 1;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned SettleCyc  = 80;
  localparam int unsigned ItemTarget = 1650;

  localparam logic [fcf_pkg::ReqWidth-1:0] REQ_UNUSED = 2'd3;

  localparam logic signed [SampleW-1:0] Q23Max = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] Q23Min = {1'b1, {(SampleW-1){1'b0}}};

  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic                      clip;
  } fir_result_t;

  class fir_scoreboard;
    logic signed [SampleW-1:0]         coef [NumTaps];
    logic signed [SampleW-1:0]         hist [NumTaps];
    logic [fcf_pkg::TapIndexWidth-1:0] head;
    logic [fcf_pkg::NumTapsWidth-1:0]  taps;
    fir_result_t                       pending [$];
    int                                errors;
    int                                checked;
    int                                clips;

    function new();
      for (int i = 0; i < NumTaps; i++) begin
        coef[i] = '0;
      end
      clear_history();
      taps    = '0;
      errors  = 0;
      checked = 0;
      clips   = 0;
    endfunction

    function void clear_history();
      for (int i = 0; i < NumTaps; i++) begin
        hist[i] = '0;
      end
      head = '0;
    endfunction

    function void set_taps(logic [fcf_pkg::NumTapsWidth-1:0] n);
      taps = n;
    endfunction

    function void note_input(logic [fcf_pkg::ReqWidth-1:0] req,
                             logic signed [SampleW-1:0] s,
                             logic [fcf_pkg::TapIndexWidth-1:0] idx,
                             logic signed [SampleW-1:0] v);
      int unsigned                       n;
      logic [fcf_pkg::TapIndexWidth-1:0] pos;
      logic signed [2*SampleW-1:0]       prod;
      logic signed [fcf_pkg::AccBits-1:0] acc;
      logic signed [63:0]                rounded;
      logic signed [63:0]                q;
      fir_result_t                       res;
      case (req)
        fcf_pkg::REQ_COEF: begin
          coef[idx] = v;
          clear_history();
        end
        fcf_pkg::REQ_CLEAR: begin
          clear_history();
        end
        fcf_pkg::REQ_SAMPLE: begin
          hist[head] = s;
          n = (taps > NumTaps) ? NumTaps : taps;
          acc = '0;
          for (int k = 0; k < n; k++) begin
            pos  = head - fcf_pkg::TapIndexWidth'(k);
            prod = coef[k] * hist[pos];
            acc  = acc + prod;
          end
          head = head + 1'b1;
          // Adding half an LSB and shifting arithmetically rounds ties upwards.
          rounded = acc + (64'sd1 <<< (FracBits - 1));
          q = rounded >>> FracBits;
          res.clip = 1'b0;
          if (q > 64'(Q23Max)) begin
            res.value = Q23Max;
            res.clip  = 1'b1;
          end else if (q < 64'(Q23Min)) begin
            res.value = Q23Min;
            res.clip  = 1'b1;
          end else begin
            res.value = q[SampleW-1:0];
          end
          pending.push_back(res);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic signed [SampleW-1:0] value, logic clip);
      fir_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, sample_out %0d clipped %0b", $time, value, clip);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.clip) begin
        clips++;
      end
      if (value !== want.value) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, want.value, value);
        errors++;
      end
      if (clip !== want.clip) begin
        $display("%0t: clipped expected %0b actual %0b", $time, want.clip, clip);
        errors++;
      end
    endfunction
  endclass

  logic                              clk_i       = 1'b0;
  logic                              rst_ni      = 1'b0;
  logic                              in_valid_i  = 1'b0;
  logic                              in_stall_o;
  logic [fcf_pkg::ReqWidth-1:0]      req_type_i  = fcf_pkg::REQ_SAMPLE;
  logic signed [SampleW-1:0]         sample_in_i = '0;
  logic [fcf_pkg::TapIndexWidth-1:0] tap_index_i = '0;
  logic signed [SampleW-1:0]         tap_value_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [SampleW-1:0]         sample_out_o;
  logic                              clipped_o;
  logic                              cfg_we_i    = 1'b0;
  logic [fcf_pkg::NumTapsWidth-1:0]  cfg_wdata_i = '0;

  fir_scoreboard sb = new();

  bit          calm        = 1'b0;
  int unsigned rx_wait     = 0;
  int unsigned idle_cycles = 0;
  int          n_items     = 0;
  int          n_samples   = 0;
  int          n_coefs     = 0;
  int          n_clears    = 0;
  int          n_ignored   = 0;
  int          n_settings  = 0;

  fir_convolution_filter_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .sample_in_i  (sample_in_i),
    .tap_index_i  (tap_index_i),
    .tap_value_i  (tap_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .clipped_o    (clipped_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic signed [SampleW-1:0] pick_q23();
    case ($urandom_range(0, 9))
      0:       return Q23Max;
      1:       return Q23Min;
      2:       return '0;
      3, 4, 5: return SampleW'(int'($urandom_range(0, 131071)) - 65536);
      default: return SampleW'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_result(sample_out_o, clipped_o);
      rx_wait = draw_wait();
    end
  end

  // The stall count only runs down while a word is on offer.
  always @(negedge clk_i) begin
    if (out_valid_o && rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait = rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(input logic [fcf_pkg::ReqWidth-1:0] req,
                      input logic signed [SampleW-1:0] s,
                      input logic [fcf_pkg::TapIndexWidth-1:0] idx,
                      input logic signed [SampleW-1:0] v);
    int unsigned gap;
    gap = draw_wait();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    sample_in_i <= s;
    tap_index_i <= idx;
    tap_value_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(req, s, idx, v);
    case (req)
      fcf_pkg::REQ_SAMPLE: n_samples++;
      fcf_pkg::REQ_COEF:   n_coefs++;
      fcf_pkg::REQ_CLEAR:  n_clears++;
      default:             n_ignored++;
    endcase
    if (req != REQ_UNUSED) begin
      n_items++;
    end
  endtask

  task automatic send_sample(input logic signed [SampleW-1:0] s);
    send(fcf_pkg::REQ_SAMPLE, s, fcf_pkg::TapIndexWidth'($urandom), SampleW'($urandom));
  endtask

  task automatic send_coef(input logic [fcf_pkg::TapIndexWidth-1:0] idx,
                           input logic signed [SampleW-1:0] v);
    send(fcf_pkg::REQ_COEF, SampleW'($urandom), idx, v);
  endtask

  task automatic send_clear();
    send(fcf_pkg::REQ_CLEAR, SampleW'($urandom), fcf_pkg::TapIndexWidth'($urandom),
         SampleW'($urandom));
  endtask

  task automatic send_unused();
    send(REQ_UNUSED, SampleW'($urandom), fcf_pkg::TapIndexWidth'($urandom),
         SampleW'($urandom));
  endtask

  // The tap count is only changed once every result is out and the row has settled.
  task automatic change_taps(input logic [fcf_pkg::NumTapsWidth-1:0] n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    sb.set_taps(n);
    n_settings++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      send_sample(pick_q23());
    end else if (r < 90) begin
      send_coef(fcf_pkg::TapIndexWidth'($urandom), pick_q23());
    end else if (r < 95) begin
      send_clear();
    end else begin
      send_unused();
    end
  endtask

  initial begin
    int unsigned                      len;
    int unsigned                      nc;
    logic [fcf_pkg::NumTapsWidth-1:0] n;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Silent filter straight after reset, and an unused request code.
    send_sample(Q23Max);
    send_sample(Q23Min);
    send_unused();
    send_coef(6'd0, Q23Max);
    send_coef(6'd1, Q23Max);
    send_coef(6'd63, Q23Min);

    change_taps(7'd2);
    send_sample(Q23Max);
    send_sample(Q23Max);
    send_sample(Q23Min);
    send_sample(Q23Min);
    send_sample('0);
    send_clear();
    send_sample(Q23Max);

    // Rounding ties with a unit coefficient.
    change_taps(7'd1);
    send_coef(6'd0, 24'sd1);
    send_sample(24'sd4194304);
    send_sample(-24'sd4194304);
    send_sample(-24'sd4194305);

    change_taps(7'd64);
    send_sample(Q23Min);
    send_sample(Q23Max);

    change_taps(7'd127);
    send_coef(6'd32, -24'sd1);
    send_sample(Q23Min);
    send_sample(Q23Max);

    while (n_items < ItemTarget) begin
      case ($urandom_range(0, 9))
        0:       n = 7'd0;
        1:       n = 7'd1;
        2:       n = 7'd64;
        3:       n = 7'd127;
        4:       n = fcf_pkg::NumTapsWidth'($urandom_range(65, 127));
        default: n = fcf_pkg::NumTapsWidth'($urandom_range(1, 64));
      endcase
      change_taps(n);
      calm = ($urandom_range(0, 3) == 0);
      nc = $urandom_range(1, 8);
      repeat (nc) begin
        send_coef(fcf_pkg::TapIndexWidth'($urandom_range(0, NumTaps - 1)), pick_q23());
      end
      len = $urandom_range(20, 100);
      repeat (len) begin
        random_word();
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    $display("Sent %0d samples, %0d coefficient writes, %0d history clears and %0d unused codes",
             n_samples, n_coefs, n_clears, n_ignored);
    $display("over %0d tap count settings; %0d results checked, %0d of them saturated.",
             n_settings, sb.checked, sb.clips);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
